[design/fpts_pkg.sv]
package fpts_pkg;

   // Number of task slots; the last slot is the idle task.
   localparam int TASK_SLOTS = 8;

   // Field widths fixed by the channel format.
   localparam int SLOT_W = 3;
   localparam int CMD_W = 2;
   localparam int TICK_W = 32;
   localparam int READY_MASK_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_YIELD = 2'd1,
      CMD_SLEEP = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DORMANT  = 2'd0,
      ST_READY    = 2'd1,
      ST_RUNNING  = 2'd2,
      ST_SLEEPING = 2'd3
   } status_type;

   // Outcome of one scheduling pass.
   typedef struct packed {
      status_type [TASK_SLOTS-1:0] status;
      logic [TASK_SLOTS-1:0]       ready;
      logic [SLOT_W-1:0]           pick;
   } pass_result_type;

endpackage

[design/fpts_sched_pass.sv]
module fpts_sched_pass
   import fpts_pkg::*;
(
   input  status_type [TASK_SLOTS-1:0]             status_in,
   input  logic       [TASK_SLOTS-1:0][TICK_W-1:0] wake_in,
   input  logic       [TASK_SLOTS-1:0]             ready_in,
   input  logic       [TICK_W-1:0]                 tick_new,
   input  logic       [SLOT_W-1:0]                 cur_slot,
   output pass_result_type                         pass_out
);

   status_type [TASK_SLOTS-1:0] woke_status;
   logic [TASK_SLOTS-1:0]       woke_ready;
   logic [SLOT_W-1:0]           pick;

   // Sleepers whose wake tick has been reached become ready.
   always_comb begin
      woke_status = status_in;
      woke_ready = ready_in;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (status_in[i] == ST_SLEEPING && tick_new >= wake_in[i]) begin
            woke_status[i] = ST_READY;
            woke_ready[i] = 1'b1;
         end
      end
   end

   // Lowest-index runnable slot wins; the idle slot is the fallback.
   always_comb begin
      pick = SLOT_W'(TASK_SLOTS - 1);
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (woke_status[i] == ST_READY || woke_status[i] == ST_RUNNING) begin
            pick = SLOT_W'(i);
         end
      end
   end

   // Demote a preempted running slot and mark the chosen slot running.
   always_comb begin
      pass_out.status = woke_status;
      pass_out.ready = woke_ready;
      pass_out.pick = pick;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (SLOT_W'(i) == pick) begin
            pass_out.status[i] = ST_RUNNING;
            pass_out.ready[i] = 1'b0;
         end else if (SLOT_W'(i) == cur_slot && woke_status[i] == ST_RUNNING) begin
            pass_out.status[i] = ST_READY;
            pass_out.ready[i] = 1'b1;
         end
      end
   end

endmodule

[design/fixed_priority_task_scheduler.sv]
// Fixed-priority task scheduler.
// Input channel (req_*): one command per transfer: tick, yield, sleep for
// req_sleep_ticks, or start slot req_task_index. Slot 0 has the highest
// priority; the last slot is the idle task, chosen when nothing can run.
// Result channel (rsp_*): one result per command with the running slot, the
// previous slot, the switch flag, the ready mask, the tick counter after the
// command and an error flag for a start beyond the last slot.
// Timing: an accepted command waits in the input register, and its result
// loads into the result register once that register is free or taken.
// Throughput: one command per cycle while results are taken; the
// command decode, the eight wake comparators and the priority pick are all
// combinational between the two registers.
// Reset clears the tick counter, all slot states to dormant, the wake ticks,
// the ready mask and the running slot to slot 0, and empties both registers.
// When the receiver stalls, the result register holds its result and the
// input register keeps one more command; req_ready drops after that until
// the result is taken.
module fixed_priority_task_scheduler
   import fpts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [SLOT_W-1:0]       req_task_index,
   input  logic [TICK_W-1:0]       req_sleep_ticks,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SLOT_W-1:0]       rsp_current_task,
   output logic                    rsp_switched,
   output logic [SLOT_W-1:0]       rsp_previous_task,
   output logic [READY_MASK_W-1:0] rsp_ready_mask,
   output logic [TICK_W-1:0]       rsp_tick_count,
   output logic                    rsp_error
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   cmd_type           in_cmd_ff;
   logic [SLOT_W-1:0] in_index_ff;
   logic [TICK_W-1:0] in_sleep_ff;

   // Scheduler state.
   status_type [TASK_SLOTS-1:0]             status_ff, status_in;
   logic       [TASK_SLOTS-1:0][TICK_W-1:0] wake_ff, wake_in;
   logic       [TASK_SLOTS-1:0]             ready_ff, ready_in;
   logic       [TICK_W-1:0]                 tick_ff, tick_in;
   logic       [SLOT_W-1:0]                 running_ff, running_in;

   // Result register.
   logic                    out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0]       out_current_ff, out_current_in;
   logic                    out_switched_ff, out_switched_in;
   logic [SLOT_W-1:0]       out_previous_ff;
   logic [READY_MASK_W-1:0] out_mask_ff, out_mask_in;
   logic [TICK_W-1:0]       out_tick_ff, out_tick_in;
   logic                    out_error_ff;

   // Command stage signals.
   logic                                    fire;
   logic                                    start_err;
   logic       [TICK_W-1:0]                 sleep_wake;
   logic       [TICK_W-1:0]                 tick_new;
   status_type [TASK_SLOTS-1:0]             cmd_status;
   logic       [TASK_SLOTS-1:0][TICK_W-1:0] cmd_wake;
   logic       [TASK_SLOTS-1:0]             cmd_ready;
   pass_result_type                         pass_res;

   // Handshake: the command stage advances when the result register frees up.
   assign fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   // A start beyond the last slot is rejected and leaves all state alone.
   assign start_err = (in_cmd_ff == CMD_START) &&
                      ({1'b0, in_index_ff} >= (SLOT_W + 1)'(TASK_SLOTS));
   assign sleep_wake = tick_ff + in_sleep_ff;
   assign tick_new = tick_ff + TICK_W'(1);

   // Apply the command to the slot states before the scheduling pass.
   always_comb begin
      cmd_status = status_ff;
      cmd_wake = wake_ff;
      cmd_ready = ready_ff;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         case (in_cmd_ff)
            CMD_START: begin
               if (!start_err && in_index_ff == SLOT_W'(i)) begin
                  cmd_status[i] = ST_READY;
                  cmd_wake[i] = '0;
                  cmd_ready[i] = 1'b1;
               end
            end
            CMD_YIELD: begin
               if (running_ff == SLOT_W'(i)) begin
                  cmd_status[i] = ST_READY;
                  cmd_ready[i] = 1'b1;
               end
            end
            CMD_SLEEP: begin
               if (running_ff == SLOT_W'(i)) begin
                  cmd_status[i] = ST_SLEEPING;
                  cmd_wake[i] = sleep_wake;
                  cmd_ready[i] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   fpts_sched_pass u_pass (
      .status_in (cmd_status),
      .wake_in   (cmd_wake),
      .ready_in  (cmd_ready),
      .tick_new  (tick_new),
      .cur_slot  (running_ff),
      .pass_out  (pass_res)
   );

   // Next state; a rejected start changes nothing.
   always_comb begin
      status_in = status_ff;
      wake_in = wake_ff;
      ready_in = ready_ff;
      tick_in = tick_ff;
      running_in = running_ff;
      if (fire && !start_err) begin
         status_in = pass_res.status;
         wake_in = cmd_wake;
         ready_in = pass_res.ready;
         tick_in = tick_new;
         running_in = pass_res.pick;
      end
   end

   // Result fields.
   assign out_current_in = start_err ? running_ff : pass_res.pick;
   assign out_switched_in = out_current_in != running_ff;
   assign out_mask_in = start_err ? READY_MASK_W'(ready_ff) : READY_MASK_W'(pass_res.ready);
   assign out_tick_in = start_err ? tick_ff : tick_new;

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff <= '{default: ST_DORMANT};
         wake_ff <= '0;
         ready_ff <= '0;
         tick_ff <= '0;
         running_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         status_ff <= status_in;
         wake_ff <= wake_in;
         ready_ff <= ready_in;
         tick_ff <= tick_in;
         running_ff <= running_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff <= cmd_type'(req_cmd);
         in_index_ff <= req_task_index;
         in_sleep_ff <= req_sleep_ticks;
      end
      if (fire) begin
         out_current_ff <= out_current_in;
         out_switched_ff <= out_switched_in;
         out_previous_ff <= running_ff;
         out_mask_ff <= out_mask_in;
         out_tick_ff <= out_tick_in;
         out_error_ff <= start_err;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_current_task = out_current_ff;
   assign rsp_switched = out_switched_ff;
   assign rsp_previous_task = out_previous_ff;
   assign rsp_ready_mask = out_mask_ff;
   assign rsp_tick_count = out_tick_ff;
   assign rsp_error = out_error_ff;

`ifndef ASSERT_OFF
   // A ready bit is set exactly when its slot is in the ready state.
   for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_ready_chk
      a_ready_match: assert property (@(posedge clock) disable iff (reset)
         ready_ff[g] == (status_ff[g] == ST_READY))
         else $error("ready bit disagrees with slot state");
   end

   // The running slot always names an existing slot.
   a_running_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, running_ff} < (SLOT_W + 1)'(TASK_SLOTS))
      else $error("running slot out of range");

   // An accepted command advances the tick counter by one.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      fire && !start_err |=> tick_ff == $past(tick_ff) + TICK_W'(1))
      else $error("tick counter did not advance");

   // A rejected start reports no switch and leaves the counter alone.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      fire && start_err |=> !rsp_switched && rsp_current_task == rsp_previous_task &&
                            tick_ff == $past(tick_ff))
      else $error("rejected start changed the schedule");
`endif

endmodule
